FILE: hdl/mcs_pkg.sv
// Shared codes, constants and controller/datapath command types for the calculator sequencer.
package mcs_pkg;

  // token kinds
  localparam logic [3:0] REQ_NUM    = 4'd0;
  localparam logic [3:0] REQ_OPER   = 4'd1;
  localparam logic [3:0] REQ_EQ     = 4'd2;
  localparam logic [3:0] REQ_PCT    = 4'd3;
  localparam logic [3:0] REQ_CLEAR  = 4'd4;
  localparam logic [3:0] REQ_MADD   = 4'd5;
  localparam logic [3:0] REQ_MSUB   = 4'd6;
  localparam logic [3:0] REQ_MCLR   = 4'd7;
  localparam logic [3:0] REQ_RECALL = 4'd8;
  localparam logic [3:0] REQ_END    = 4'd9;

  // operator codes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_END  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;
  localparam logic [1:0] ST_SAT  = 2'd3;

  // entry phases
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_TERM   = 2'd2;

  // register update selects
  localparam logic [2:0] UPD_NONE    = 3'd0;
  localparam logic [2:0] UPD_SIMPLE  = 3'd1;
  localparam logic [2:0] UPD_ADDSUB  = 3'd2;
  localparam logic [2:0] UPD_PCT_B   = 3'd3;
  localparam logic [2:0] UPD_MUL_RES = 3'd4;
  localparam logic [2:0] UPD_DIV_RES = 3'd5;
  localparam logic [2:0] UPD_DIVZERO = 3'd6;

  // arithmetic unit launch selects
  localparam logic [1:0] ARITH_NONE = 2'd0;
  localparam logic [1:0] ARITH_MUL  = 2'd1;
  localparam logic [1:0] ARITH_DIV  = 2'd2;
  localparam logic [1:0] ARITH_PCT  = 2'd3;

  // arithmetic unit modes
  localparam logic [1:0] ARM_MUL = 2'd0;
  localparam logic [1:0] ARM_DIV = 2'd1;
  localparam logic [1:0] ARM_PCT = 2'd2;

  localparam int unsigned PCT_DIVISOR = 100;

  // x / 100 == (x * 5243) >> 19 for every x below 43699
  localparam logic [12:0] PCT_RECIP       = 13'd5243;
  localparam int          PCT_RECIP_SHIFT = 19;

  typedef struct packed {
    logic       latch_tok;
    logic [2:0] upd;
    logic [1:0] arith;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic       halted;
    logic [1:0] phase;
    logic [3:0] kind;
    logic [1:0] op;
    logic       b_zero;
    logic       arith_busy;
  } sts_t;

endpackage

FILE: hdl/mcs_req_if.sv
// Request channel: one keypad token per transfer.
interface mcs_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic [1:0]  operator_code;
  logic [62:0] number_value;

  modport source (output valid, req_type, operator_code, number_value, input ready);
  modport sink (input valid, req_type, operator_code, number_value, output ready);
endinterface

FILE: hdl/mcs_res_if.sv
// Result channel: display value, status and entry phase after each token.
interface mcs_res_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] display_value;
  logic [1:0]         status;
  logic [1:0]         entry_phase_out;

  modport source (output valid, display_value, status, entry_phase_out, input ready);
  modport sink (input valid, display_value, status, entry_phase_out, output ready);
endinterface

FILE: hdl/mcs_arith.sv
// Iterative unsigned arithmetic: shift-add multiply, restoring divide and a bytewise divide by 100.
module mcs_arith import mcs_pkg::*; #(
  parameter int VALUE_WIDTH   = 64,
  parameter int FRACTION_BITS = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [1:0]             mode_i,
  input  logic [VALUE_WIDTH-1:0] mul_a_i,
  input  logic [VALUE_WIDTH-1:0] mul_b_i,
  input  logic [((2 * VALUE_WIDTH > VALUE_WIDTH + FRACTION_BITS) ? 2 * VALUE_WIDTH :
                 VALUE_WIDTH + FRACTION_BITS)-1:0] dividend_i,
  input  logic [VALUE_WIDTH-1:0] divisor_i,
  output logic                   busy_o,
  output logic [((2 * VALUE_WIDTH > VALUE_WIDTH + FRACTION_BITS) ? 2 * VALUE_WIDTH :
                 VALUE_WIDTH + FRACTION_BITS)-1:0] res_o
);
  localparam int VW = VALUE_WIDTH;
  localparam int DW = (2 * VALUE_WIDTH > VALUE_WIDTH + FRACTION_BITS) ?
                      2 * VALUE_WIDTH : VALUE_WIDTH + FRACTION_BITS;
  localparam int PW = ((DW + 7) / 8) * 8;
  localparam int CW = $clog2(DW + 1);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [1:0]    mode_q, mode_d;
  logic [PW-1:0] acc_q, acc_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] opa_q, opa_d;

  logic [VW:0]   mul_sum;
  logic [VW:0]   r_sh;
  logic          r_ge;

  logic [14:0]   pct_n;
  logic [27:0]   pct_p;
  logic [7:0]    pct_q;
  logic [6:0]    pct_r;

  always_comb begin
    mul_sum = {1'b0, acc_q[2*VW-1:VW]} + (acc_q[0] ? {1'b0, opa_q} : '0);
    r_sh    = {rem_q, acc_q[DW-1]};
    r_ge    = r_sh >= {1'b0, opa_q};
    // one quotient byte per cycle; the remainder stays below 100
    pct_n   = {rem_q[6:0], acc_q[PW-1:PW-8]};
    pct_p   = {13'd0, pct_n} * {15'd0, PCT_RECIP};
    pct_q   = pct_p[PCT_RECIP_SHIFT +: 8];
    pct_r   = 7'(pct_n - {7'd0, pct_q} * 15'(PCT_DIVISOR));
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    mode_d = mode_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    opa_d  = opa_q;
    if (start_i) begin
      busy_d = 1'b1;
      mode_d = mode_i;
      rem_d  = '0;
      if (mode_i == ARM_MUL) begin
        cnt_d = CW'(VW);
        opa_d = mul_a_i;
        acc_d = PW'(mul_b_i);
      end else if (mode_i == ARM_PCT) begin
        cnt_d = CW'(PW / 8);
        opa_d = divisor_i;
        acc_d = PW'(dividend_i);
      end else begin
        cnt_d = CW'(DW);
        opa_d = divisor_i;
        acc_d = PW'(dividend_i);
      end
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
      if (mode_q == ARM_MUL) begin
        acc_d = PW'({mul_sum, acc_q[VW-1:1]});
      end else if (mode_q == ARM_PCT) begin
        rem_d = VW'(pct_r);
        acc_d = {acc_q[PW-9:0], pct_q};
      end else begin
        rem_d = r_ge ? VW'(r_sh - {1'b0, opa_q}) : VW'(r_sh);
        acc_d = PW'({acc_q[DW-2:0], r_ge});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    opa_q  <= opa_d;
  end

  assign busy_o = busy_q;
  assign res_o  = acc_q[DW-1:0];
endmodule

FILE: hdl/mcs_datapath.sv
// Calculator registers, saturating add/sub, saturation of wide results and output register.
module mcs_datapath import mcs_pkg::*; #(
  parameter int VALUE_WIDTH   = 64,
  parameter int FRACTION_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [3:0]         req_type_i,
  input  logic [1:0]         operator_code_i,
  input  logic [62:0]        number_value_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  output logic signed [63:0] display_value_o,
  output logic [1:0]         status_o,
  output logic [1:0]         entry_phase_out_o
);
  localparam int VW = VALUE_WIDTH;
  localparam int DW = (2 * VALUE_WIDTH > VALUE_WIDTH + FRACTION_BITS) ?
                      2 * VALUE_WIDTH : VALUE_WIDTH + FRACTION_BITS;

  localparam logic [62:0]   NUM_MAX = 63'((64'd1 << (VW - 1)) - 64'd1);
  localparam logic [VW-1:0] VMAX    = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VMIN    = {1'b1, {(VW-1){1'b0}}};
  localparam logic [DW-1:0] LIM_POS = DW'({(VW-1){1'b1}});
  localparam logic [DW-1:0] LIM_NEG = LIM_POS + DW'(1);

  function automatic logic [VW-1:0] mag(input logic [VW-1:0] v);
    return v[VW-1] ? (~v + 1'b1) : v;
  endfunction

  logic [3:0]    kind_q, kind_d;
  logic [1:0]    opc_q, opc_d;
  logic [VW-1:0] val_q, val_d;
  logic          sat_q, sat_d;
  logic [VW-1:0] result_q, result_d;
  logic [VW-1:0] memory_q, memory_d;
  logic [VW-1:0] first_q, first_d;
  logic [VW-1:0] second_q, second_d;
  logic [1:0]    pend_q, pend_d;
  logic [1:0]    phase_q, phase_d;
  logic [1:0]    halt_q, halt_d;

  logic signed [63:0] disp_q;
  logic [1:0]         stat_q;
  logic [1:0]         ph_out_q;

  logic          clamp;
  logic [62:0]   num_val;

  logic [VW-1:0] as_x, as_y;
  logic          as_sub;
  logic [VW:0]   as_ext;
  logic          as_ovf;
  logic [VW-1:0] as_res;

  logic          neg;
  logic [DW-1:0] sf_m;
  logic          sf_ovf;
  logic [VW-1:0] sf_res;

  logic          ar_start;
  logic [1:0]    ar_mode;
  logic [DW-1:0] ar_dividend;
  logic [VW-1:0] ar_divisor;
  logic          ar_busy;
  logic [DW-1:0] ar_res;
  logic [VW-1:0] tok_val;

  always_comb begin
    clamp   = number_value_i > NUM_MAX;
    num_val = clamp ? NUM_MAX : number_value_i;
    tok_val = VW'(num_val);
  end

  // saturating add/sub, shared by memory keys and the add/subtract operators
  always_comb begin
    if (cmd_i.upd == UPD_ADDSUB) begin
      as_x   = first_q;
      as_y   = second_q;
      as_sub = pend_q == OP_SUB;
    end else begin
      as_x   = memory_q;
      as_y   = result_q;
      as_sub = kind_q == REQ_MSUB;
    end
    as_ext = as_sub ? ({as_x[VW-1], as_x} - {as_y[VW-1], as_y})
                    : ({as_x[VW-1], as_x} + {as_y[VW-1], as_y});
    as_ovf = as_ext[VW] ^ as_ext[VW-1];
    as_res = as_ovf ? (as_ext[VW] ? VMIN : VMAX) : as_ext[VW-1:0];
  end

  // signed saturation of a wide magnitude
  always_comb begin
    neg    = first_q[VW-1] ^ second_q[VW-1];
    sf_m   = (cmd_i.upd == UPD_MUL_RES) ? (ar_res >> FRACTION_BITS) : ar_res;
    sf_ovf = sf_m > (neg ? LIM_NEG : LIM_POS);
    if (sf_ovf) begin
      sf_res = neg ? VMIN : VMAX;
    end else begin
      sf_res = neg ? (~sf_m[VW-1:0] + 1'b1) : sf_m[VW-1:0];
    end
  end

  always_comb begin
    ar_start    = cmd_i.arith != ARITH_NONE;
    ar_mode     = (cmd_i.arith == ARITH_MUL) ? ARM_MUL :
                  ((cmd_i.arith == ARITH_PCT) ? ARM_PCT : ARM_DIV);
    ar_dividend = (cmd_i.arith == ARITH_PCT) ? (ar_res >> FRACTION_BITS)
                                             : (DW'(mag(first_q)) << FRACTION_BITS);
    ar_divisor  = mag(second_q);
  end

  mcs_arith #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_arith (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ar_start),
    .mode_i     (ar_mode),
    .mul_a_i    (mag(first_q)),
    .mul_b_i    (mag(second_q)),
    .dividend_i (ar_dividend),
    .divisor_i  (ar_divisor),
    .busy_o     (ar_busy),
    .res_o      (ar_res)
  );

  always_comb begin
    kind_d   = kind_q;
    opc_d    = opc_q;
    val_d    = val_q;
    sat_d    = sat_q;
    result_d = result_q;
    memory_d = memory_q;
    first_d  = first_q;
    second_d = second_q;
    pend_d   = pend_q;
    phase_d  = phase_q;
    halt_d   = halt_q;

    if (cmd_i.latch_tok) begin
      kind_d = req_type_i;
      opc_d  = operator_code_i;
      val_d  = tok_val;
      sat_d  = (req_type_i == REQ_NUM) && clamp && (halt_q == ST_OK);
    end

    case (cmd_i.upd)
      UPD_SIMPLE: begin
        if (kind_q >= REQ_CLEAR) begin
          case (kind_q)
            REQ_CLEAR:  result_d = '0;
            REQ_MADD, REQ_MSUB: begin
              memory_d = as_res;
              sat_d    = sat_q | as_ovf;
            end
            REQ_MCLR:   memory_d = '0;
            REQ_RECALL: result_d = memory_q;
            default:    halt_d   = ST_END;
          endcase
          phase_d  = PH_FIRST;
          first_d  = '0;
          second_d = '0;
          pend_d   = OP_ADD;
        end else if (phase_q == PH_FIRST) begin
          if (kind_q == REQ_OPER) begin
            pend_d  = opc_q;
            phase_d = PH_SECOND;
          end else begin
            first_d  = (kind_q == REQ_NUM) ? val_q : '0;
            result_d = (kind_q == REQ_NUM) ? val_q : '0;
          end
        end else if (phase_q == PH_SECOND) begin
          second_d = (kind_q == REQ_NUM) ? val_q : '0;
          result_d = (kind_q == REQ_NUM) ? val_q : '0;
          phase_d  = PH_TERM;
        end else begin
          // drop the token and restart
          phase_d  = PH_FIRST;
          first_d  = '0;
          second_d = '0;
          pend_d   = OP_ADD;
        end
      end
      UPD_ADDSUB, UPD_MUL_RES, UPD_DIV_RES: begin
        if (cmd_i.upd == UPD_ADDSUB) begin
          result_d = as_res;
          sat_d    = sat_q | as_ovf;
        end else begin
          result_d = sf_res;
          sat_d    = sat_q | sf_ovf;
        end
        phase_d  = PH_FIRST;
        first_d  = '0;
        second_d = '0;
        pend_d   = OP_ADD;
      end
      UPD_PCT_B: begin
        second_d = sf_res;
        sat_d    = sat_q | sf_ovf;
      end
      UPD_DIVZERO: begin
        halt_d   = ST_DIVZ;
        phase_d  = PH_FIRST;
        first_d  = '0;
        second_d = '0;
        pend_d   = OP_ADD;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_q <= '0;
      memory_q <= '0;
      first_q  <= '0;
      second_q <= '0;
      pend_q   <= OP_ADD;
      phase_q  <= PH_FIRST;
      halt_q   <= ST_OK;
    end else begin
      result_q <= result_d;
      memory_q <= memory_d;
      first_q  <= first_d;
      second_q <= second_d;
      pend_q   <= pend_d;
      phase_q  <= phase_d;
      halt_q   <= halt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    opc_q  <= opc_d;
    val_q  <= val_d;
    sat_q  <= sat_d;
    if (cmd_i.out_load) begin
      disp_q   <= 64'($signed(result_q));
      stat_q   <= (halt_q != ST_OK) ? halt_q : (sat_q ? ST_SAT : ST_OK);
      ph_out_q <= phase_q;
    end
  end

  always_comb begin
    sts_o.halted     = halt_q != ST_OK;
    sts_o.phase      = phase_q;
    sts_o.kind       = kind_q;
    sts_o.op         = pend_q;
    sts_o.b_zero     = second_q == '0;
    sts_o.arith_busy = ar_busy;
  end

  assign display_value_o   = disp_q;
  assign status_o          = stat_q;
  assign entry_phase_out_o = ph_out_q;
endmodule

FILE: hdl/mcs_ctrl.sv
// Sequencer state machine: token decode, arithmetic scheduling and result handshake.
module mcs_ctrl import mcs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_PCT_MUL_W = 4'd2;
  localparam logic [3:0] S_PCT_DIV_W = 4'd3;
  localparam logic [3:0] S_OPER      = 4'd4;
  localparam logic [3:0] S_MUL_W     = 4'd5;
  localparam logic [3:0] S_DIV_W     = 4'd6;
  localparam logic [3:0] S_OUT       = 4'd7;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       load;

  assign load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.out_load = load;
    in_ready_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_tok = 1'b1;
          state_d         = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.halted || (sts_i.kind > REQ_END)) begin
          state_d = S_OUT;
        end else if (sts_i.kind < REQ_CLEAR && sts_i.phase == PH_TERM &&
                     sts_i.kind == REQ_PCT) begin
          cmd_o.arith = ARITH_MUL;
          state_d     = S_PCT_MUL_W;
        end else if (sts_i.kind < REQ_CLEAR && sts_i.phase == PH_TERM &&
                     sts_i.kind == REQ_EQ) begin
          state_d = S_OPER;
        end else begin
          cmd_o.upd = UPD_SIMPLE;
          state_d   = S_OUT;
        end
      end
      S_PCT_MUL_W: begin
        if (!sts_i.arith_busy) begin
          cmd_o.arith = ARITH_PCT;
          state_d     = S_PCT_DIV_W;
        end
      end
      S_PCT_DIV_W: begin
        if (!sts_i.arith_busy) begin
          cmd_o.upd = UPD_PCT_B;
          state_d   = S_OPER;
        end
      end
      S_OPER: begin
        case (sts_i.op)
          OP_ADD, OP_SUB: begin
            cmd_o.upd = UPD_ADDSUB;
            state_d   = S_OUT;
          end
          OP_MUL: begin
            cmd_o.arith = ARITH_MUL;
            state_d     = S_MUL_W;
          end
          default: begin
            if (sts_i.b_zero) begin
              cmd_o.upd = UPD_DIVZERO;
              state_d   = S_OUT;
            end else begin
              cmd_o.arith = ARITH_DIV;
              state_d     = S_DIV_W;
            end
          end
        endcase
      end
      S_MUL_W: begin
        if (!sts_i.arith_busy) begin
          cmd_o.upd = UPD_MUL_RES;
          state_d   = S_OUT;
        end
      end
      S_DIV_W: begin
        if (!sts_i.arith_busy) begin
          cmd_o.upd = UPD_DIV_RES;
          state_d   = S_OUT;
        end
      end
      S_OUT: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // hold the result until taken; a new load replaces a taken one
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
endmodule

FILE: hdl/memory_calculator_sequencer.sv
// Top level of the four-function memory calculator sequencer.
// Usage: tokens enter on req_i (valid/ready); each accepted request yields exactly
// one result on res_o: the shown value (signed fixed point, sign-extended to 64
// bits), a status code and the entry phase after the token.
// Requests are taken one at a time; req_i.ready is high only while the sequencer
// is idle. Multiply, divide and percent run on the shared arithmetic unit,
// which retires one product or quotient bit per cycle, or one quotient byte for
// the division by 100. The next request can be accepted in the cycle after its
// predecessor's result is loaded.
// A finished result sits in an output register; a new request may be worked
// on while it waits, but its own result holds until res_o is free.
// Reset clears all calculator state (result, memory, operands, phase, halt)
// and empties the output register. After an end token or a divide by zero
// every token is ignored until reset, echoing the held value and halt status.
module memory_calculator_sequencer import mcs_pkg::*; #(
  parameter int VALUE_WIDTH   = 64,
  parameter int FRACTION_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mcs_req_if.sink     req_i,
  mcs_res_if.source   res_o
);
  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;

  mcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mcs_datapath #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_type_i        (req_i.req_type),
    .operator_code_i   (req_i.operator_code),
    .number_value_i    (req_i.number_value),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .display_value_o   (res_o.display_value),
    .status_o          (res_o.status),
    .entry_phase_out_o (res_o.entry_phase_out)
  );

  assign req_i.ready = in_ready;
  assign res_o.valid = out_valid;
endmodule

FILE: tb/sv/tb_memory_calculator_sequencer.sv
// Self-checking testbench for the memory calculator sequencer: keypad token stream vs. predicted display.
module tb_memory_calculator_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import mcs_pkg::*;

  localparam int          FRAC        = 24;
  localparam logic [63:0] VMAX        = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] VMIN        = 64'h8000_0000_0000_0000;
  localparam logic [62:0] NUM_MAX     = {63{1'b1}};
  localparam logic [3:0]  REQ_UNUSED  = REQ_END + 4'd1;
  localparam int          ITEM_TARGET = 1050;
  localparam int          DRAIN       = 400;
  localparam int unsigned LIMIT       = 2000000;

  typedef struct packed {
    logic [3:0]  kind;
    logic [1:0]  opc;
    logic [62:0] num;
  } key_t;

  // calculator state plus the status of the last token
  typedef struct packed {
    logic [63:0] shown;
    logic [63:0] mem;
    logic [63:0] opa;
    logic [63:0] opb;
    logic [1:0]  op;
    logic [1:0]  phase;
    logic [1:0]  halt;
    logic [1:0]  status;
  } calc_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mcs_req_if req_if ();
  mcs_res_if res_if ();

  memory_calculator_sequencer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  key_t        key_q[$];
  calc_t       shown_q[$];
  calc_t       gen_state;
  calc_t       calc_model;
  calc_t       want;
  key_t        cur_key;
  int          req_gap;
  int          res_stall;
  bit          req_calm;
  bit          res_calm;
  int          errors;
  int          n_queued;
  int          n_live;
  int          n_accepted;
  int          n_checked;
  int          n_sat;
  int unsigned n_cycles;

  function automatic key_t make_key(logic [3:0] kind, logic [1:0] opc, logic [62:0] num);
    key_t k;
    k.kind = kind;
    k.opc  = opc;
    k.num  = num;
    return k;
  endfunction

  function automatic logic [63:0] mag(logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  // saturate a wide magnitude with sign; bit 64 flags saturation
  function automatic logic [64:0] clamp_mag(logic [127:0] m, logic neg);
    logic [127:0] lim;
    lim = neg ? {64'd0, VMIN} : {64'd0, VMAX};
    if (m > lim) return {1'b1, neg ? VMIN : VMAX};
    return {1'b0, neg ? (~m[63:0] + 64'd1) : m[63:0]};
  endfunction

  function automatic logic [64:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return {1'b1, a[63] ? VMIN : VMAX};
    return {1'b0, s};
  endfunction

  function automatic logic [64:0] sub_sat(logic [63:0] a, logic [63:0] b);
    logic [63:0] d;
    d = a - b;
    if (a[63] != b[63] && d[63] != a[63]) return {1'b1, a[63] ? VMIN : VMAX};
    return {1'b0, d};
  endfunction

  // product after the fraction shift, optionally divided down to a percentage
  function automatic logic [64:0] scale_sat(logic [63:0] a, logic [63:0] b, bit pct);
    logic [127:0] p;
    p = ({64'd0, mag(a)} * {64'd0, mag(b)}) >> FRAC;
    if (pct) p = p / 128'(PCT_DIVISOR);
    return clamp_mag(p, a[63] ^ b[63]);
  endfunction

  function automatic logic [64:0] div_sat(logic [63:0] a, logic [63:0] b);
    logic [127:0] q;
    q = ({64'd0, mag(a)} << FRAC) / {64'd0, mag(b)};
    return clamp_mag(q, a[63] ^ b[63]);
  endfunction

  function automatic calc_t restart_entry(calc_t s);
    s.phase = PH_FIRST;
    s.opa   = '0;
    s.opb   = '0;
    s.op    = OP_ADD;
    return s;
  endfunction

  function automatic calc_t calc_next(calc_t s, key_t k);
    logic [63:0] val;
    logic [63:0] a;
    logic [63:0] b;
    logic [64:0] r;
    logic        sat;
    sat = 1'b0;
    val = {1'b0, k.num};
    if (val > VMAX) begin
      val = VMAX;
      sat = (k.kind == REQ_NUM);
    end
    if (s.halt == ST_OK && k.kind <= REQ_END) begin
      if (k.kind >= REQ_CLEAR) begin
        case (k.kind)
          REQ_CLEAR: s.shown = '0;
          REQ_MADD: begin
            r = add_sat(s.mem, s.shown);
            s.mem = r[63:0];
            sat |= r[64];
          end
          REQ_MSUB: begin
            r = sub_sat(s.mem, s.shown);
            s.mem = r[63:0];
            sat |= r[64];
          end
          REQ_MCLR: s.mem = '0;
          REQ_RECALL: s.shown = s.mem;
          default: s.halt = ST_END;
        endcase
        s = restart_entry(s);
      end else if (s.phase == PH_FIRST) begin
        if (k.kind == REQ_OPER) begin
          s.op    = k.opc;
          s.phase = PH_SECOND;
        end else begin
          s.opa   = (k.kind == REQ_NUM) ? val : '0;
          s.shown = s.opa;
        end
      end else if (s.phase == PH_SECOND) begin
        s.opb   = (k.kind == REQ_NUM) ? val : '0;
        s.shown = s.opb;
        s.phase = PH_TERM;
      end else begin
        // numbers and operators here are dropped; only equals/percent compute
        if (k.kind == REQ_EQ || k.kind == REQ_PCT) begin
          a = s.opa;
          b = s.opb;
          if (k.kind == REQ_PCT) begin
            r = scale_sat(a, b, 1'b1);
            b = r[63:0];
            sat |= r[64];
          end
          if (s.op == OP_DIV && b == '0) begin
            s.halt = ST_DIVZ;
          end else begin
            case (s.op)
              OP_ADD:  r = add_sat(a, b);
              OP_SUB:  r = sub_sat(a, b);
              OP_MUL:  r = scale_sat(a, b, 1'b0);
              default: r = div_sat(a, b);
            endcase
            s.shown = r[63:0];
            sat |= r[64];
          end
        end
        s = restart_entry(s);
      end
    end else begin
      sat = 1'b0;
    end
    s.status = (s.halt != ST_OK) ? s.halt : (sat ? ST_SAT : ST_OK);
    return s;
  endfunction

  function automatic logic [62:0] rand_num();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return NUM_MAX;
      2:       return 63'($urandom_range(0, 1000)) << FRAC;
      3:       return 63'({$urandom_range(0, 255), 24'($urandom)});
      4:       return 63'({$urandom, $urandom});
      default: return 63'($urandom_range(0, 255));
    endcase
  endfunction

  // queue a request; unless a halt is wanted, swap a halting token for a clear
  task automatic queue_key(input key_t k, input bit may_halt);
    calc_t nxt;
    nxt = calc_next(gen_state, k);
    if (!may_halt && gen_state.halt == ST_OK && nxt.halt != ST_OK) begin
      k   = make_key(REQ_CLEAR, k.opc, k.num);
      nxt = calc_next(gen_state, k);
    end
    if (gen_state.halt == ST_OK && k.kind <= REQ_END) n_live++;
    key_q.push_back(k);
    n_queued++;
    gen_state = nxt;
  endtask

  task automatic queue_sequence();
    logic [3:0] kind;
    if ($urandom_range(0, 9) == 0) queue_key(make_key(REQ_NUM, 2'($urandom), rand_num()), 1'b0);
    if ($urandom_range(0, 9) != 0) queue_key(make_key(REQ_NUM, 2'($urandom), rand_num()), 1'b0);
    queue_key(make_key(REQ_OPER, 2'($urandom), rand_num()), 1'b0);
    kind = ($urandom_range(0, 14) == 0) ? 4'($urandom_range(REQ_OPER, REQ_PCT)) : REQ_NUM;
    queue_key(make_key(kind, 2'($urandom), rand_num()), 1'b0);
    if ($urandom_range(0, 14) == 0) kind = 4'($urandom_range(REQ_NUM, REQ_OPER));
    else kind = ($urandom_range(0, 4) < 3) ? REQ_EQ : REQ_PCT;
    queue_key(make_key(kind, 2'($urandom), rand_num()), 1'b0);
    if ($urandom_range(0, 5) == 0)
      queue_key(make_key(4'($urandom_range(REQ_CLEAR, REQ_RECALL)), 2'($urandom), rand_num()),
                1'b0);
  endtask

  task automatic launch_next();
    cur_key              = key_q.pop_front();
    req_if.valid         <= 1'b1;
    req_if.req_type      <= cur_key.kind;
    req_if.operator_code <= cur_key.opc;
    req_if.number_value  <= cur_key.num;
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (req_if.valid && req_if.ready) begin
      calc_model = calc_next(calc_model, cur_key);
      shown_q.push_back(calc_model);
      n_accepted++;
      if ($urandom_range(0, 49) == 0) req_calm = !req_calm;
      req_gap = req_calm ? 0 : $urandom_range(0, 9);
      if (req_gap == 0 && key_q.size() != 0) launch_next();
      else req_if.valid <= 1'b0;
    end else if (!req_if.valid) begin
      if (req_gap > 0) req_gap--;
      else if (key_q.size() != 0) launch_next();
    end
  end

  // result monitor: hold ready low for a drawn number of valid cycles
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b1;
    end else if (res_if.valid && res_if.ready) begin
      if (shown_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: value %0d status %0d phase %0d", $time,
                 res_if.display_value, res_if.status, res_if.entry_phase_out);
      end else begin
        want = shown_q.pop_front();
        n_checked++;
        if (want.status == ST_SAT) n_sat++;
        if (res_if.display_value !== want.shown) begin
          errors++;
          $display("%0t: display_value expected %0d got %0d", $time, $signed(want.shown),
                   res_if.display_value);
        end
        if (res_if.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, want.status, res_if.status);
        end
        if (res_if.entry_phase_out !== want.phase) begin
          errors++;
          $display("%0t: entry_phase_out expected %0d got %0d", $time, want.phase,
                   res_if.entry_phase_out);
        end
      end
      if ($urandom_range(0, 49) == 0) res_calm = !res_calm;
      res_stall = res_calm ? 0 : $urandom_range(0, 9);
      res_if.ready <= (res_stall == 0);
    end else if (res_if.valid && res_stall > 0) begin
      res_stall--;
      res_if.ready <= (res_stall == 0);
    end
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, shown_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.req_type      = REQ_NUM;
    req_if.operator_code = OP_ADD;
    req_if.number_value  = '0;
    res_if.ready         = 1'b0;
    gen_state            = '0;
    calc_model           = '0;
    cur_key              = '0;
    req_gap              = 0;
    res_stall            = 0;
    req_calm             = 1'b0;
    res_calm             = 1'b0;
    errors               = 0;
    n_queued             = 0;
    n_live               = 0;
    n_accepted           = 0;
    n_checked            = 0;
    n_sat                = 0;
    n_cycles             = 0;

    // directed: saturation both ways, memory keys, misplaced tokens, percent
    queue_key(make_key(REQ_NUM, OP_ADD, NUM_MAX), 1'b0);
    queue_key(make_key(REQ_OPER, OP_ADD, '0), 1'b0);
    queue_key(make_key(REQ_NUM, OP_ADD, 63'd1 << FRAC), 1'b0);
    queue_key(make_key(REQ_EQ, OP_ADD, '0), 1'b0);
    queue_key(make_key(REQ_MADD, OP_ADD, '0), 1'b0);
    queue_key(make_key(REQ_MADD, OP_ADD, '0), 1'b0);
    queue_key(make_key(REQ_EQ, OP_ADD, '0), 1'b0);
    queue_key(make_key(REQ_OPER, OP_SUB, '0), 1'b0);
    queue_key(make_key(REQ_NUM, OP_SUB, NUM_MAX), 1'b0);
    queue_key(make_key(REQ_EQ, OP_SUB, '0), 1'b0);
    queue_key(make_key(REQ_MSUB, OP_SUB, '0), 1'b0);
    queue_key(make_key(REQ_RECALL, OP_SUB, '0), 1'b0);
    queue_key(make_key(REQ_MCLR, OP_SUB, '0), 1'b0);
    queue_key(make_key(REQ_NUM, OP_MUL, 63'd50 << FRAC), 1'b0);
    queue_key(make_key(REQ_OPER, OP_MUL, '0), 1'b0);
    queue_key(make_key(REQ_PCT, OP_MUL, '0), 1'b0);
    queue_key(make_key(REQ_NUM, OP_MUL, NUM_MAX), 1'b0);
    queue_key(make_key(REQ_NUM, OP_ADD, 63'd200 << FRAC), 1'b0);
    queue_key(make_key(REQ_OPER, OP_ADD, '0), 1'b0);
    queue_key(make_key(REQ_NUM, OP_ADD, 63'd10 << FRAC), 1'b0);
    queue_key(make_key(REQ_PCT, OP_ADD, '0), 1'b0);
    queue_key(make_key(REQ_NUM, OP_DIV, NUM_MAX), 1'b0);
    queue_key(make_key(REQ_OPER, OP_DIV, '0), 1'b0);
    queue_key(make_key(REQ_NUM, OP_DIV, 63'd1), 1'b0);
    queue_key(make_key(REQ_EQ, OP_DIV, '0), 1'b0);
    queue_key(make_key(4'hF, OP_DIV, NUM_MAX), 1'b0);
    queue_key(make_key(REQ_CLEAR, OP_ADD, '0), 1'b0);

    // random: mostly complete sequences, some function keys and noise
    while (n_queued < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1:    queue_key(make_key(4'($urandom_range(REQ_CLEAR, REQ_RECALL)), 2'($urandom),
                                    rand_num()), 1'b0);
        2:       queue_key(make_key(4'($urandom_range(0, 15)), 2'($urandom), rand_num()), 1'b0);
        3:       queue_key(make_key(4'($urandom_range(REQ_UNUSED, 15)), 2'($urandom),
                                    rand_num()), 1'b0);
        default: queue_sequence();
      endcase
    end

    // close with one halt, then tokens that must all be ignored
    if ($urandom_range(0, 1) == 0) begin
      queue_key(make_key(REQ_END, 2'($urandom), rand_num()), 1'b1);
    end else begin
      queue_key(make_key(REQ_CLEAR, 2'($urandom), rand_num()), 1'b1);
      queue_key(make_key(REQ_NUM, 2'($urandom), rand_num()), 1'b1);
      queue_key(make_key(REQ_OPER, OP_DIV, rand_num()), 1'b1);
      queue_key(make_key(REQ_NUM, 2'($urandom), '0), 1'b1);
      queue_key(make_key($urandom_range(0, 1) ? REQ_EQ : REQ_PCT, 2'($urandom), rand_num()),
                1'b1);
    end
    repeat (12) queue_key(make_key(4'($urandom_range(0, 15)), 2'($urandom), rand_num()), 1'b1);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_queued || shown_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (shown_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, shown_q.size());
    end
    $display("Drove %0d keypad requests (%0d acted on); compared %0d results", n_queued, n_live,
             n_checked);
    $display("%0d results saturated; run closed with halt status %0d", n_sat, calc_model.halt);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/mcs_pkg.sv
hdl/mcs_req_if.sv
hdl/mcs_res_if.sv
hdl/mcs_arith.sv
hdl/mcs_datapath.sv
hdl/mcs_ctrl.sv
hdl/memory_calculator_sequencer.sv
tb/sv/tb_memory_calculator_sequencer.sv
